// ----- rtl/puha_pkg.sv -----
// Package for the pair utility hash accumulator: status codes, FSM states,
// hash constants and controller/datapath command and status structs.
// No dependencies.
package puha_pkg;

  localparam int unsigned TableSizeDef = 4096;
  localparam int unsigned KeyW = 64;
  localparam int unsigned SumW = 48;
  localparam logic [63:0] MixC1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixC2 = 64'h94d049bb133111eb;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_INSERT  = 3'd1,
    ST_FULL    = 3'd2,
    ST_ZERO    = 3'd3,
    ST_READ    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_H1, S_M1A, S_M1B, S_H2, S_M2A, S_M2B, S_H3,
    S_PROBE, S_CHECK, S_RDWAIT, S_OUT
  } state_t;

  // 32x32 partial product helper for the staged 64-bit multiply
  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    mul32 = {32'd0, a} * {32'd0, b};
  endfunction

  typedef struct packed {
    logic clr_wr;      // write zero at clear pointer
    logic load;        // capture request
    logic h1;          // first xor-shift
    logic m_a;         // low/cross products
    logic m_b;         // combine products
    logic h2;          // second xor-shift
    logic h3;          // final xor-shift, set home
    logic rd;          // issue memory read at probe pointer
    logic adv;         // advance probe pointer
    logic wr_new;      // insert key and sum
    logic wr_add;      // write updated sum
    logic emit;        // drive result
    logic [2:0] stat;  // status for the result
    logic show;        // show slot contents
  } ctl_t;

  typedef struct packed {
    logic is_read;
    logic empty;
    logic match;
    logic util_zero;
    logic clr_done;
    logic probes_done;
    logic second_mul;
  } sts_t;

endpackage

// ----- rtl/puha_datapath.sv -----
// Datapath: staged splitmix64 hash, key/sum memories, probe pointer, counter.
// Depends on puha_pkg.
module puha_datapath
  import puha_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TableSizeDef,
  localparam int unsigned IdxW = $clog2(TABLE_SIZE)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic        in_func,
  input  logic [31:0] in_start_item,
  input  logic [31:0] in_end_item,
  input  logic [31:0] in_add_utility,
  input  logic [11:0] in_read_slot,
  output logic        out_strobe_d,
  output logic [2:0]  out_status,
  output logic [11:0] out_slot,
  output logic        out_slot_used,
  output logic [31:0] out_key_start,
  output logic [31:0] out_key_end,
  output logic [47:0] out_utility_sum,
  output logic [12:0] out_entries_used
);

  logic [KeyW-1:0] key_mem [TABLE_SIZE];
  logic [SumW-1:0] sum_mem [TABLE_SIZE];

  logic            func_r;
  logic [63:0]     key_r, v_r, lo_r;
  logic [31:0]     util_r, xhi_r;
  logic            second_r;
  logic [IdxW-1:0] home_r, ptr_r, clr_r;
  logic [IdxW:0]   cnt_r, occ_r;
  logic [KeyW-1:0] rkey_r;
  logic [SumW-1:0] rsum_r;
  logic [SumW:0]   add_w;
  logic [63:0]     cst;
  logic [63:0]     p_ll, p_hl, p_lh;

  assign cst = second_r ? MixC2 : MixC1;
  assign add_w = {1'b0, rsum_r} + {17'd0, util_r};

  // partial products of the 64-bit multiply
  assign p_ll = mul32(v_r[31:0], cst[31:0]);
  assign p_hl = mul32(v_r[63:32], cst[31:0]);
  assign p_lh = mul32(v_r[31:0], cst[63:32]);

  // clear sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (ctl.clr_wr) clr_r <= clr_r + 1'b1;
  end

  // memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.clr_wr) begin
      key_mem[clr_r] <= '0;
      sum_mem[clr_r] <= '0;
    end else if (ctl.wr_new) begin
      key_mem[ptr_r] <= key_r;
      sum_mem[ptr_r] <= {16'd0, util_r};
    end else if (ctl.wr_add) begin
      sum_mem[ptr_r] <= add_w[SumW] ? SumMax : add_w[SumW-1:0];
    end
    if (ctl.rd) begin
      rkey_r <= key_mem[ptr_r];
      rsum_r <= sum_mem[ptr_r];
    end
  end

  // request capture and hash stages
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func_r   <= in_func;
      key_r    <= {in_start_item, in_end_item};
      v_r      <= {in_start_item, in_end_item};
      util_r   <= in_add_utility;
      ptr_r    <= IdxW'(in_read_slot);
      second_r <= 1'b0;
    end
    if (ctl.h1) v_r <= v_r ^ (v_r >> 30);
    if (ctl.m_a) begin
      lo_r  <= p_ll;
      xhi_r <= p_hl[31:0];
    end
    if (ctl.m_b) begin
      v_r <= lo_r + {(xhi_r + p_lh[31:0]), 32'd0};
      second_r <= 1'b1;
    end
    if (ctl.h2) v_r <= v_r ^ (v_r >> 27);
    if (ctl.h3) begin
      home_r <= v_r[IdxW-1:0] ^ v_r[IdxW+30:31];
      ptr_r  <= v_r[IdxW-1:0] ^ v_r[IdxW+30:31];
      cnt_r  <= '0;
    end
    if (ctl.adv) begin
      ptr_r <= ptr_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // occupancy counter
  always_ff @(posedge clk) begin
    if (!rst_n) occ_r <= '0;
    else if (ctl.wr_new) occ_r <= occ_r + 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_d <= 1'b0;
    else out_strobe_d <= ctl.emit;
    if (ctl.emit) begin
      out_status <= ctl.stat;
      out_slot <= 12'(ctl.stat == ST_FULL ? home_r : ptr_r);
      out_entries_used <= 13'(occ_r + {{IdxW{1'b0}}, ctl.wr_new});
      if (!ctl.show) begin
        out_slot_used <= 1'b0;
        out_key_start <= '0;
        out_key_end <= '0;
        out_utility_sum <= '0;
      end else if (ctl.wr_new) begin
        out_slot_used <= 1'b1;
        out_key_start <= key_r[63:32];
        out_key_end <= key_r[31:0];
        out_utility_sum <= {16'd0, util_r};
      end else begin
        out_slot_used <= ctl.wr_add ? 1'b1 : (rsum_r != '0);
        out_key_start <= rkey_r[63:32];
        out_key_end <= rkey_r[31:0];
        out_utility_sum <= ctl.wr_add ? (add_w[SumW] ? SumMax : add_w[SumW-1:0]) : rsum_r;
      end
    end
  end

  assign sts.is_read     = func_r;
  assign sts.empty       = (rsum_r == '0);
  assign sts.match       = (rkey_r == key_r);
  assign sts.util_zero   = (util_r == '0);
  assign sts.clr_done    = (clr_r == IdxW'(TABLE_SIZE - 1));
  assign sts.probes_done = (cnt_r == (IdxW+1)'(TABLE_SIZE));
  assign sts.second_mul  = second_r;

endmodule

// ----- rtl/puha_ctrl.sv -----
// Controller FSM: clearing sweep, hash sequencing, probe loop, slot read, result issue.
// Depends on puha_pkg.
module puha_ctrl
  import puha_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) begin
        ctl.load = 1'b1;
        state_nxt = S_H1;
      end
      S_H1: begin
        if (sts.is_read) begin
          ctl.rd = 1'b1;
          state_nxt = S_RDWAIT;
        end else begin
          ctl.h1 = 1'b1;
          state_nxt = S_M1A;
        end
      end
      S_M1A: begin ctl.m_a = 1'b1; state_nxt = S_M1B; end
      S_M1B: begin
        ctl.m_b = 1'b1;
        state_nxt = sts.second_mul ? S_H3 : S_H2;
      end
      S_H2: begin ctl.h2 = 1'b1; state_nxt = S_M1A; end
      S_H3: begin ctl.h3 = 1'b1; state_nxt = S_PROBE; end
      S_PROBE: begin
        if (sts.probes_done) begin
          ctl.emit = 1'b1;
          ctl.stat = ST_FULL;
          state_nxt = S_IDLE;
        end else begin
          ctl.rd = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.empty) begin
          ctl.emit = 1'b1;
          if (sts.util_zero) ctl.stat = ST_ZERO;
          else begin
            ctl.stat = ST_INSERT;
            ctl.show = 1'b1;
            ctl.wr_new = 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (sts.match) begin
          ctl.emit = 1'b1;
          ctl.stat = ST_ADDED;
          ctl.show = 1'b1;
          ctl.wr_add = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ctl.adv = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_RDWAIT: begin
        ctl.emit = 1'b1;
        ctl.stat = ST_READ;
        ctl.show = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/pair_utility_hash_accumulator.sv -----
// Top level of the pair utility hash accumulator: controller plus datapath.
// Depends on puha_pkg, puha_ctrl, puha_datapath.
//
// Channel  Ports                           Handshake
// input    in_func .. in_read_slot         start && !busy
// result   out_status .. out_entries_used  out_strobe, one cycle, no stall
//
// A read issues the memory read in S_H1 and goes through S_RDWAIT; its result
// appears as busy drops. An accumulate hashes through S_H1, S_M1A, S_M1B, S_H2,
// S_M1A, S_M1B, S_H3 (two 64-bit multiplies as 32-bit partial products combined
// in S_M1B), then reads a slot in S_PROBE and checks it in S_CHECK per probe on
// the single registered memory read port; its result appears as busy drops. A
// full table probes every slot. After reset a clearing pass zeroes each slot, busy high.
module pair_utility_hash_accumulator
  import puha_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TableSizeDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_start_item,
  input  logic [31:0] in_end_item,
  input  logic [31:0] in_add_utility,
  input  logic [11:0] in_read_slot,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [11:0] out_slot,
  output logic        out_slot_used,
  output logic [31:0] out_key_start,
  output logic [31:0] out_key_end,
  output logic [47:0] out_utility_sum,
  output logic [12:0] out_entries_used
);

  ctl_t ctl;
  sts_t sts;

  puha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  puha_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_func(in_func), .in_start_item(in_start_item), .in_end_item(in_end_item),
    .in_add_utility(in_add_utility), .in_read_slot(in_read_slot),
    .out_strobe_d(out_strobe), .out_status(out_status), .out_slot(out_slot),
    .out_slot_used(out_slot_used), .out_key_start(out_key_start),
    .out_key_end(out_key_end), .out_utility_sum(out_utility_sum),
    .out_entries_used(out_entries_used)
  );

`ifndef SYNTHESIS
  // a result is issued only once the controller is back to idle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result while busy");
  // results leave a slot in use only for insert, add and read
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_FULL || out_status == ST_ZERO)) |-> !out_slot_used)
    else $error("slot shown on empty status");
  // an insert always stores a nonzero sum
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_INSERT) |-> out_utility_sum != '0)
    else $error("insert with zero sum");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for pair_utility_hash_accumulator: accumulate and read
// requests, checked against an in-bench hash-map predictor. Depends on puha_pkg.
`timescale 1ns / 1ps

module tb;
  import puha_pkg::*;

  localparam int unsigned SLOTS = 4096;
  localparam logic [11:0] SLOT_MASK = 12'(SLOTS - 1);
  localparam int unsigned FUNC_ACC = 0;
  localparam int unsigned FUNC_RD = 1;

  typedef struct packed {
    status_t     status;
    logic [11:0] slot;
    logic        used;
    logic [31:0] kstart;
    logic [31:0] kend;
    logic [47:0] sum;
    logic [12:0] entries;
  } map_result_t;

  typedef struct packed {
    logic        func;
    logic [31:0] sitem;
    logic [31:0] eitem;
    logic [31:0] util;
    logic [11:0] rslot;
    logic        has_exp;
    map_result_t exp;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_func = 1'b0;
  logic [31:0] in_start_item = '0, in_end_item = '0, in_add_utility = '0;
  logic [11:0] in_read_slot = '0;
  logic out_strobe;
  logic [2:0] out_status;
  logic [11:0] out_slot;
  logic out_slot_used;
  logic [31:0] out_key_start, out_key_end;
  logic [47:0] out_utility_sum;
  logic [12:0] out_entries_used;

  // predictor state
  logic [63:0] pred_keys[SLOTS];
  logic [47:0] pred_sums[SLOTS];
  int unsigned pred_count;

  map_result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned n_inserts = 0, n_adds = 0, n_reads = 0, n_zero = 0;
  int unsigned n_sat = 0;

  always #10 clk = ~clk;

  pair_utility_hash_accumulator DUT (.*);

  function automatic logic [31:0] splitmix_low(input logic [63:0] v);
    logic [63:0] x;
    x = (v ^ (v >> 30)) * MixC1;
    x = (x ^ (x >> 27)) * MixC2;
    x = x ^ (x >> 31);
    return x[31:0];
  endfunction

  // apply one request to the predicted map, return its result
  function automatic map_result_t map_apply(input request_t r);
    map_result_t res;
    logic [63:0] key;
    logic [48:0] total;
    logic [31:0] hv;
    logic [11:0] h, home;
    bit done;
    res = '0;
    if (r.func) begin
      h = r.rslot & SLOT_MASK;
      res.status = ST_READ;
      res.slot = h;
      res.used = pred_sums[h] != 0;
      res.kstart = pred_keys[h][63:32];
      res.kend = pred_keys[h][31:0];
      res.sum = pred_sums[h];
      res.entries = 13'(pred_count);
      return res;
    end
    key = {r.sitem, r.eitem};
    hv = splitmix_low(key);
    home = hv[11:0] & SLOT_MASK;
    h = home;
    done = 0;
    for (int n = 0; n < SLOTS && !done; n++) begin
      if (pred_sums[h] == 0) begin
        done = 1;
        res.slot = h;
        if (r.util == 0) begin
          res.status = ST_ZERO;
        end else begin
          pred_keys[h] = key;
          pred_sums[h] = 48'(r.util);
          pred_count++;
          res.status = ST_INSERT;
        end
      end else if (pred_keys[h] == key) begin
        done = 1;
        total = pred_sums[h] + r.util;
        pred_sums[h] = total > SumMax ? SumMax : total[47:0];
        res.status = ST_ADDED;
        res.slot = h;
      end else begin
        h = h + 1'b1;
      end
    end
    if (!done) begin
      res.status = ST_FULL;
      res.slot = home;
    end else if (res.status != ST_ZERO) begin
      res.used = pred_sums[h] != 0;
      res.kstart = pred_keys[h][63:32];
      res.kend = pred_keys[h][31:0];
      res.sum = pred_sums[h];
    end
    res.entries = 13'(pred_count);
    return res;
  endfunction

  // result monitor
  always @(posedge clk) begin
    map_result_t got, want;
    if (rst_n && out_strobe) begin
      results_seen++;
      got = '{status_t'(out_status), out_slot, out_slot_used, out_key_start,
              out_key_end, out_utility_sum, out_entries_used};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // start stays high after acceptance until the next request or idle cycle
  task automatic send_request(input request_t r, input bit allow_idle);
    map_result_t res;
    if (allow_idle) begin
      while ($urandom_range(99) < 11) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_func <= r.func;
    in_start_item <= r.sitem;
    in_end_item <= r.eitem;
    in_add_utility <= r.util;
    in_read_slot <= r.rslot;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = map_apply(r);
    if (r.has_exp && res !== r.exp) begin
      mismatches++;
      if (mismatches <= 10) $display("table row: expected %p predicted %p", r.exp, res);
    end
    case (res.status)
      ST_INSERT: n_inserts++;
      ST_ADDED: n_adds++;
      ST_READ: n_reads++;
      default: n_zero++;
    endcase
    if (res.sum == SumMax) n_sat++;
    pending_results.push_back(res);
  endtask

  function automatic request_t acc_req(input logic [31:0] s, e, u);
    request_t r;
    r = '0;
    r.func = 1'(FUNC_ACC);
    r.sitem = s;
    r.eitem = e;
    r.util = u;
    return r;
  endfunction

  function automatic request_t read_req(input logic [11:0] idx);
    request_t r;
    r = '0;
    r.func = 1'(FUNC_RD);
    r.rslot = idx;
    r.sitem = $urandom;
    r.eitem = $urandom;
    r.util = $urandom;
    return r;
  endfunction

  request_t directed_rows[$];
  logic [31:0] key_pool_s[16], key_pool_e[16];

  initial begin
    request_t r;
    int k;
    for (int i = 0; i < SLOTS; i++) begin
      pred_keys[i] = '0;
      pred_sums[i] = '0;
    end
    pred_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; fixed expectations only where obvious
    r = read_req(12'd0);
    r.has_exp = 1;
    r.exp = '{ST_READ, 12'd0, 1'b0, 32'd0, 32'd0, 48'd0, 13'd0};
    directed_rows.push_back(r);
    r = read_req(12'hFFF);
    r.has_exp = 1;
    r.exp = '{ST_READ, 12'hFFF, 1'b0, 32'd0, 32'd0, 48'd0, 13'd0};
    directed_rows.push_back(r);
    directed_rows.push_back(acc_req(32'd0, 32'd0, 32'd0));          // zero, missing key
    directed_rows.push_back(acc_req(32'd0, 32'd0, 32'hFFFF_FFFF));  // insert all-zero key
    directed_rows.push_back(acc_req(32'd0, 32'd0, 32'd0));          // add zero, existing key
    directed_rows.push_back(acc_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
    directed_rows.push_back(acc_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed_rows.push_back(acc_req(32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000));
    directed_rows.push_back(acc_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000));
    directed_rows.push_back(acc_req(32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF));
    // saturating one sum needs about 65537 max-utility adds on one key,
    // far more than this run sends
    for (int i = 0; i < 8; i++) directed_rows.push_back(read_req(12'($urandom)));
    foreach (directed_rows[i]) send_request(directed_rows[i], 1'b1);

    // hot key pool so adds and probe chains dominate
    for (int i = 0; i < 16; i++) begin
      key_pool_s[i] = $urandom;
      key_pool_e[i] = $urandom;
    end
    for (int n = 0; n < 450; n++) begin
      k = $urandom_range(15);
      case ($urandom_range(9))
        0, 1: r = read_req(12'($urandom));
        2: r = acc_req($urandom, $urandom, $urandom_range(1) ? 32'd0 : $urandom);
        3: r = acc_req($urandom, $urandom, $urandom);
        default: r = acc_req(key_pool_s[k], key_pool_e[k],
                             $urandom_range(3) == 0 ? 32'd0 : $urandom);
      endcase
      send_request(r, n < 150 || n >= 300);
    end

    // closing burst of random slot reads
    for (int i = 0; i < 16; i++) send_request(read_req(12'($urandom)), 1'b0);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d results: %0d inserts, %0d adds, %0d reads, %0d zero/full",
             results_seen, n_inserts, n_adds, n_reads, n_zero);
    $display("entries in use at end: %0d, saturated sums seen: %0d", pred_count, n_sat);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

endmodule
